FILE: sv/blls_pkg.sv
`timescale 1ns / 1ps

package blls_pkg;

  // Coordinate width and the width of the signed decision term.
  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // Everything that describes the line in progress.
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t stop_x;
    coord_t stop_y;
    err_t   err;
    coord_t delta_major;
    coord_t delta_minor;
    logic   steep;
    logic   minor_down;
    logic   active;
  } line_state_t;

endpackage

FILE: sv/blls_setup.sv
`timescale 1ns / 1ps

// Builds the line state for a load: axis spans, major axis, endpoint order,
// minor direction and the initial decision term.
module blls_setup import blls_pkg::*; (
  input  coord_t      start_x,
  input  coord_t      start_y,
  input  coord_t      end_x,
  input  coord_t      end_y,
  output line_state_t setup_st
);

  coord_t dx;
  coord_t dy;
  logic   steep;
  logic   swap;
  coord_t dmaj;
  coord_t dmin;
  coord_t c_x;
  coord_t c_y;
  coord_t s_x;
  coord_t s_y;

  always_comb begin
    dx    = (start_x > end_x) ? start_x - end_x : end_x - start_x;
    dy    = (start_y > end_y) ? start_y - end_y : end_y - start_y;
    steep = dy > dx;
    dmaj  = steep ? dy : dx;
    dmin  = steep ? dx : dy;
    swap  = steep ? (end_y < start_y) : (end_x < start_x);
    c_x   = swap ? end_x : start_x;
    c_y   = swap ? end_y : start_y;
    s_x   = swap ? start_x : end_x;
    s_y   = swap ? start_y : end_y;

    setup_st.cur_x       = c_x;
    setup_st.cur_y       = c_y;
    setup_st.stop_x      = s_x;
    setup_st.stop_y      = s_y;
    setup_st.delta_major = dmaj;
    setup_st.delta_minor = dmin;
    setup_st.steep       = steep;
    setup_st.minor_down  = steep ? (s_x < c_x) : (s_y < c_y);
    setup_st.err         = err_t'({1'b0, dmin, 1'b0}) - err_t'({2'b00, dmaj});
    setup_st.active      = dmaj != '0;
  end

endmodule

FILE: sv/blls_step.sv
`timescale 1ns / 1ps

// One step along the major axis, with the minor axis following when the
// decision term is not negative.
module blls_step import blls_pkg::*; (
  input  line_state_t cur_st,
  output line_state_t step_st
);

  coord_t major;
  coord_t minor;
  coord_t major_inc;
  coord_t minor_mov;
  coord_t major_stop;
  err_t   two_min;
  err_t   two_maj;

  always_comb begin
    major      = cur_st.steep ? cur_st.cur_y : cur_st.cur_x;
    minor      = cur_st.steep ? cur_st.cur_x : cur_st.cur_y;
    major_stop = cur_st.steep ? cur_st.stop_y : cur_st.stop_x;
    major_inc  = major + coord_t'(1);
    minor_mov  = minor;
    two_min    = err_t'({1'b0, cur_st.delta_minor, 1'b0});
    two_maj    = err_t'({1'b0, cur_st.delta_major, 1'b0});

    step_st = cur_st;
    if (cur_st.err[ERR_BITS-1]) begin
      step_st.err = cur_st.err + two_min;
    end else begin
      minor_mov   = cur_st.minor_down ? minor - coord_t'(1) : minor + coord_t'(1);
      step_st.err = cur_st.err + two_min - two_maj;
    end
    step_st.cur_x  = cur_st.steep ? minor_mov : major_inc;
    step_st.cur_y  = cur_st.steep ? major_inc : minor_mov;
    step_st.active = major_inc != major_stop;
  end

endmodule

FILE: sv/bresenham_line_stepper.sv
`timescale 1ns / 1ps

// Bresenham line stepper. A load transfer (cmd = 0) takes two endpoints,
// picks the major axis, orders the endpoints along it and returns the first
// pixel in that order; each step transfer (cmd = 1) returns the next pixel of
// the line, with out_last marking the final one. A step with no line in
// progress returns a result with out_pixel_valid low and all other fields
// zero. A load abandons any line in progress. The block takes one transfer
// per clock cycle, unless the result side stalls it, and returns one result
// per transfer via the input register and the result register; the pixel
// state loop (one add and one compare on the decision term) is not pipelined.
module bresenham_line_stepper import blls_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_cmd,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_pixel_x,
  output coord_t out_pixel_y,
  output logic   out_pixel_valid,
  output logic   out_last
);

  // Input register.
  logic   stg_vld_r;
  logic   stg_cmd_r;
  coord_t stg_sx_r;
  coord_t stg_sy_r;
  coord_t stg_ex_r;
  coord_t stg_ey_r;

  // Line state and result register.
  line_state_t st_r;
  line_state_t st_nxt;
  logic        out_vld_r;
  coord_t      px_r;
  coord_t      py_r;
  logic        pv_r;
  logic        last_r;
  coord_t      px_nxt;
  coord_t      py_nxt;
  logic        pv_nxt;
  logic        last_nxt;

  line_state_t setup_st;
  line_state_t step_st;
  logic        advance;

  blls_setup u_setup (
    .start_x  (stg_sx_r),
    .start_y  (stg_sy_r),
    .end_x    (stg_ex_r),
    .end_y    (stg_ey_r),
    .setup_st (setup_st)
  );

  blls_step u_step (
    .cur_st  (st_r),
    .step_st (step_st)
  );

  // The staged item moves into the result register when that register is
  // empty or its content is taken in this same cycle.
  assign advance  = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || advance;

  always_comb begin
    st_nxt   = st_r;
    px_nxt   = '0;
    py_nxt   = '0;
    pv_nxt   = 1'b0;
    last_nxt = 1'b0;
    if (stg_cmd_r == CMD_LOAD) begin
      st_nxt   = setup_st;
      px_nxt   = setup_st.cur_x;
      py_nxt   = setup_st.cur_y;
      pv_nxt   = 1'b1;
      last_nxt = !setup_st.active;
    end else if (st_r.active) begin
      st_nxt   = step_st;
      px_nxt   = step_st.cur_x;
      py_nxt   = step_st.cur_y;
      pv_nxt   = 1'b1;
      last_nxt = !step_st.active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_cmd_r <= in_cmd;
      stg_sx_r  <= in_start_x;
      stg_sy_r  <= in_start_y;
      stg_ex_r  <= in_end_x;
      stg_ey_r  <= in_end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pv_r   <= pv_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_valid = pv_r;
  assign out_last        = last_r;

  // A held result was produced from the line state now in place: a
  // non-final pixel means pixels remain, a final pixel means none do.
  a_active_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && pv_r && !last_r) |-> st_r.active)
    else $error("line not active after a non-final pixel");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && last_r) |-> !st_r.active)
    else $error("line still active after its final pixel");

  // An empty result register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with an empty result register");

  // The last flag only rides on a real pixel.
  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && last_r) |-> pv_r)
    else $error("last flag on an invalid pixel");

endmodule
